@@ rtl/est_pkg.sv @@
// Package for the escape sequence tokenizer.
// Holds parse modes, character codes, widths and the listed-escape lookup.
// No dependencies.
package est_pkg;

  localparam int CP_W = 21;
  localparam int ACC_W = 24;
  localparam int MAX_HEX_DIGITS_DEF = 6;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_ESC       = 3'd1,
    MODE_AFTER_U   = 3'd2,
    MODE_HEX       = 3'd3,
    MODE_ERR_BRACE = 3'd4,
    MODE_ERR_HEX   = 3'd5,
    MODE_ERR_LEN   = 3'd6
  } est_mode_t;

  typedef logic [CP_W-1:0] est_cp_t;

  localparam est_cp_t CH_BSL    = 21'h5C;
  localparam est_cp_t CH_U      = 21'h75;
  localparam est_cp_t CH_LBRACE = 21'h7B;
  localparam est_cp_t CH_RBRACE = 21'h7D;
  localparam est_cp_t CH_A      = 21'h61;
  localparam est_cp_t CH_B      = 21'h62;
  localparam est_cp_t CH_E      = 21'h65;
  localparam est_cp_t CH_F      = 21'h66;
  localparam est_cp_t CH_N      = 21'h6E;
  localparam est_cp_t CH_R      = 21'h72;
  localparam est_cp_t CH_T      = 21'h74;
  localparam est_cp_t CH_V      = 21'h76;
  localparam est_cp_t CH_0      = 21'h30;
  localparam est_cp_t CH_9      = 21'h39;
  localparam est_cp_t CH_UP_A   = 21'h41;
  localparam est_cp_t CH_UP_F   = 21'h46;

  typedef struct packed {
    est_mode_t        status;
    logic             token_valid;
    logic [ACC_W-1:0] token_codepoint;
    logic             was_escaped;
    logic             plain_escape;
  } est_result_t;

  // Character code for a listed escape letter or backslash, zero when not listed.
  function automatic logic [7:0] simple_escape(input est_cp_t c);
    logic [7:0] s;
    begin
      unique case (c)
        CH_A:    s = 8'h07;
        CH_B:    s = 8'h08;
        CH_E:    s = 8'h1B;
        CH_F:    s = 8'h0C;
        CH_N:    s = 8'h0A;
        CH_R:    s = 8'h0D;
        CH_T:    s = 8'h09;
        CH_V:    s = 8'h0B;
        CH_BSL:  s = 8'h5C;
        default: s = 8'h00;
      endcase
      return s;
    end
  endfunction

endpackage

@@ rtl/est_decode.sv @@
// Next-state and token logic of the escape sequence tokenizer.
// Purely combinational; depends on est_pkg.
module est_decode #(
  parameter int MAX_HEX_DIGITS = est_pkg::MAX_HEX_DIGITS_DEF,
  parameter int CNT_W = $clog2(MAX_HEX_DIGITS + 2)
) (
  input  est_pkg::est_cp_t              c,
  input  est_pkg::est_mode_t            mode,
  input  logic [CNT_W-1:0]              cnt,
  input  logic [est_pkg::ACC_W-1:0]     acc,
  output est_pkg::est_mode_t            mode_nxt,
  output logic [CNT_W-1:0]              cnt_nxt,
  output logic [est_pkg::ACC_W-1:0]     acc_nxt,
  output est_pkg::est_result_t          res
);
  import est_pkg::*;

  logic [7:0]       esc_char;
  logic             is_hex;
  logic [3:0]       hex_val;
  logic [CNT_W-1:0] cnt_inc;

  assign esc_char = simple_escape(c);
  assign cnt_inc  = cnt + CNT_W'(1);

  always_comb begin
    is_hex  = 1'b1;
    hex_val = c[3:0];
    if (c >= CH_0 && c <= CH_9) begin
      hex_val = c[3:0];
    end else if ((c >= CH_A && c <= CH_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    mode_nxt = mode;
    cnt_nxt  = cnt;
    acc_nxt  = acc;
    res.token_valid     = 1'b0;
    res.token_codepoint = '0;
    res.was_escaped     = 1'b0;
    res.plain_escape    = 1'b0;
    unique case (mode)
      MODE_IDLE: begin
        if (c == CH_BSL) begin
          mode_nxt = MODE_ESC;
        end else begin
          res.token_valid     = 1'b1;
          res.token_codepoint = ACC_W'(c);
        end
      end
      MODE_ESC: begin
        if (esc_char != 8'h00) begin
          res.token_valid     = 1'b1;
          res.token_codepoint = ACC_W'(esc_char);
          res.was_escaped     = 1'b1;
          mode_nxt            = MODE_IDLE;
        end else if (c == CH_U) begin
          mode_nxt = MODE_AFTER_U;
        end else begin
          res.token_valid     = 1'b1;
          res.token_codepoint = ACC_W'(c);
          res.was_escaped     = 1'b1;
          res.plain_escape    = 1'b1;
          mode_nxt            = MODE_IDLE;
        end
      end
      MODE_AFTER_U: begin
        if (c == CH_LBRACE) begin
          mode_nxt = MODE_HEX;
          cnt_nxt  = '0;
          acc_nxt  = '0;
        end else begin
          mode_nxt = MODE_ERR_BRACE;
        end
      end
      MODE_HEX: begin
        if (c == CH_RBRACE) begin
          res.token_valid     = 1'b1;
          res.token_codepoint = acc;
          res.was_escaped     = 1'b1;
          mode_nxt            = MODE_IDLE;
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc > CNT_W'(MAX_HEX_DIGITS)) begin
            mode_nxt = MODE_ERR_LEN;
          end else if (!is_hex) begin
            mode_nxt = MODE_ERR_HEX;
          end else begin
            acc_nxt = {acc[ACC_W-5:0], hex_val};
          end
        end
      end
      default: begin
      end
    endcase
    res.status = mode_nxt;
  end

endmodule

@@ rtl/escape_sequence_tokenizer.sv @@
// Top level of the escape sequence tokenizer: input register, parse state,
// result register and handshakes. Depends on est_pkg and est_decode.
//
//   channel | direction | tdata                       | tuser
//   in_     | slave     | codepoint [20:0]            | -
//   out_    | master    | token_codepoint [23:0]      | status, token_valid,
//           |           |                             | was_escaped, plain_escape
//
// One item per cycle sustained while out_tready stays high. Each item passes
// through the input register and then the result register to out_tvalid.
// The parse mode, digit count and hex accumulator update in the same cycle
// that an item moves from the input register into the result register.
// rst_n (synchronous, active low) returns the parser to idle and empties both
// registers. A stalled output holds its item and back-pressures the input.
module escape_sequence_tokenizer #(
  parameter int MAX_HEX_DIGITS = est_pkg::MAX_HEX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] codepoint
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] token_codepoint
  output logic [5:0]  out_tuser   // [2:0] status, [3] token_valid, [4] was_escaped,
                                  // [5] plain_escape
);
  import est_pkg::*;

  localparam int CNT_W = $clog2(MAX_HEX_DIGITS + 2);

  logic             in_vld_r;
  est_cp_t          in_cp_r;
  logic             out_vld_r;
  est_result_t      res_r;
  est_mode_t        mode_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0] acc_r;

  est_mode_t        mode_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic [ACC_W-1:0] acc_nxt;
  est_result_t      res_nxt;
  logic             move;
  logic             in_acc;

  assign move      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || move;
  assign in_acc    = in_tvalid && in_tready;

  est_decode #(
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS),
    .CNT_W(CNT_W)
  ) u_decode (
    .c        (in_cp_r),
    .mode     (mode_r),
    .cnt      (cnt_r),
    .acc      (acc_r),
    .mode_nxt (mode_nxt),
    .cnt_nxt  (cnt_nxt),
    .acc_nxt  (acc_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r    <= MODE_IDLE;
      cnt_r     <= '0;
      acc_r     <= '0;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (move) begin
        in_vld_r <= 1'b0;
      end
      if (move) begin
        out_vld_r <= 1'b1;
        mode_r    <= mode_nxt;
        cnt_r     <= cnt_nxt;
        acc_r     <= acc_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_cp_r <= in_tdata[CP_W-1:0];
    end
    if (move) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r.token_codepoint;
  assign out_tuser  = {res_r.plain_escape, res_r.was_escaped, res_r.token_valid,
                       res_r.status};

  // Error modes are sticky until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ERR_BRACE || mode_r == MODE_ERR_HEX || mode_r == MODE_ERR_LEN)
    |=> mode_r == $past(mode_r))
    else $error("error mode left without reset");

  // Inside a hex sequence the digit count never passes the limit.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HEX |-> cnt_r <= CNT_W'(MAX_HEX_DIGITS))
    else $error("digit count beyond limit in hex mode");

  // A shown result with no token carries a zero codepoint and no flags.
  a_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !res_r.token_valid) |->
    (res_r.token_codepoint == '0 && !res_r.was_escaped && !res_r.plain_escape))
    else $error("token fields set without a token");

  // A literal escape is always an escaped token.
  a_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.plain_escape) |-> (res_r.was_escaped && res_r.token_valid))
    else $error("plain escape without escaped token");

  // The result status matches the parse mode it left behind.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> res_r.status == mode_r)
    else $error("status differs from parse mode");

endmodule
